### rtl/core/mwu_pkg.sv
// Shared types and constants for the momentum weight update block.
`timescale 1ns / 1ps
`default_nettype none

package mwu_pkg;

    localparam int DATA_W  = 32;
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 10;
    localparam int COEF_W  = 16;

    // Item commands.
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BACK   = 2'd2;

    // Register indexes, taken from address bit 2.
    localparam logic REG_LEARNING_RATE = 1'b0;
    localparam logic REG_MOMENTUM      = 1'b1;

    localparam logic [COEF_W-1:0] LEARNING_RATE_RST = 16'd1638;
    localparam logic [COEF_W-1:0] MOMENTUM_RST      = 16'd14746;

    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic read;
        logic mult;
        logic sum;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/core/momentum_weight_update.sv
// Top level of the momentum weight update block: register port and core wiring.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake                      | Payload
// ----------+--------------------------------+---------------------------------------------
// input     | i_in_valid / o_in_ready        | i_cmd, i_entry_index, i_data_value
// result    | o_out_valid / i_out_ready      | o_weight_out, o_step_out, o_restored_gradient,
//           |                                | o_saturated
// registers | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// An item is accepted in the idle state and passes the read, multiply and sum states to the
// write state, where its result is registered; no new item is taken until the block is idle.
// The order is set by the sequence on the single table port: read the entry, multiply, round
// and clip the step, then add to the weight and write back. Both products form side by side.
// A result that waits for its consumer does not block the next item; only the final write
// stage holds until the output register is free. Reset is synchronous and active low; it
// restores the learning rate and momentum registers and empties the pipeline. The table
// itself is not cleared: an entry is meaningful once it has been loaded.

module momentum_weight_update
    import mwu_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Item input
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [CMD_W-1:0]         i_cmd,
    input  wire logic [INDEX_W-1:0]       i_entry_index,
    input  wire logic signed [DATA_W-1:0] i_data_value,
    // Result output
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [DATA_W-1:0]      o_weight_out,
    output logic signed [DATA_W-1:0]      o_step_out,
    output logic signed [DATA_W-1:0]      o_restored_gradient,
    output logic                          o_saturated,
    // Register port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [2:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [COEF_W-1:0] r_learning_rate;
    logic [COEF_W-1:0] r_momentum;
    logic              cfg_write;
    t_dp_cmd           dp_cmd;
    t_dp_stat          dp_stat;

    // The port never stalls; a write lands at the end of its access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learning_rate <= LEARNING_RATE_RST;
            r_momentum      <= MOMENTUM_RST;
        end else if (cfg_write) begin
            if (paddr[2] == REG_MOMENTUM) begin
                r_momentum <= pwdata[COEF_W-1:0];
            end else begin
                r_learning_rate <= pwdata[COEF_W-1:0];
            end
        end
    end

    // Reads return the selected coefficient, zero extended.
    assign prdata = (paddr[2] == REG_LEARNING_RATE) ? {16'b0, r_learning_rate}
                                                    : {16'b0, r_momentum};

    // The controller walks each item through read, multiply, round and write back.
    mwu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    // The datapath holds the table, the arithmetic and the result register.
    mwu_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .o_stat              (dp_stat),
        .i_op                (i_cmd),
        .i_entry_index       (i_entry_index),
        .i_data_value        (i_data_value),
        .i_learning_rate     (r_learning_rate),
        .i_momentum          (r_momentum),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_weight_out        (o_weight_out),
        .o_step_out          (o_step_out),
        .o_restored_gradient (o_restored_gradient),
        .o_saturated         (o_saturated)
    );

endmodule

`default_nettype wire

### rtl/core/mwu_ctrl.sv
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module mwu_ctrl
    import mwu_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_SUM,
        S_WGT
    } t_state;

    t_state r_state;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.capture = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.read    = (r_state == S_READ);
    assign o_cmd.mult    = (r_state == S_MUL);
    assign o_cmd.sum     = (r_state == S_SUM);
    assign o_cmd.finish  = (r_state == S_WGT) && !i_stat.out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_state <= S_WGT;
                end
                S_WGT: begin
                    if (!i_stat.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.read, o_cmd.mult, o_cmd.sum, o_cmd.finish}))
        else $error("more than one datapath command at once");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_READ))
        else $error("accepted item did not start a table read");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !i_stat.out_busy)
        else $error("result finished into a full output register");

endmodule

`default_nettype wire

### rtl/core/mwu_datapath.sv
// Datapath: parameter table, momentum arithmetic, saturation and result register.
`timescale 1ns / 1ps
`default_nettype none

module mwu_datapath
    import mwu_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_stat                      o_stat,
    input  wire logic [CMD_W-1:0]         i_op,
    input  wire logic [INDEX_W-1:0]       i_entry_index,
    input  wire logic signed [DATA_W-1:0] i_data_value,
    input  wire logic [COEF_W-1:0]        i_learning_rate,
    input  wire logic [COEF_W-1:0]        i_momentum,
    input  wire logic                     i_out_ready,
    output logic                          o_out_valid,
    output logic signed [DATA_W-1:0]      o_weight_out,
    output logic signed [DATA_W-1:0]      o_step_out,
    output logic signed [DATA_W-1:0]      o_restored_gradient,
    output logic                          o_saturated
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int EXT_W  = 17;
    localparam int PROD_W = DATA_W + COEF_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RND    = 14;

    // Table storage, no reset: entries are defined once loaded.
    logic [DATA_W-1:0] r_weight_mem [ENTRIES];
    logic [DATA_W-1:0] r_step_mem   [ENTRIES];
    logic [DATA_W-1:0] r_grad_mem   [ENTRIES];

    logic [CMD_W-1:0]          r_op;
    logic [IDX_W-1:0]          r_addr;
    logic                      r_in_range;
    logic signed [DATA_W-1:0]  r_data;
    logic signed [DATA_W-1:0]  r_rd_weight;
    logic signed [DATA_W-1:0]  r_rd_step;
    logic signed [DATA_W-1:0]  r_rd_grad;
    logic signed [PROD_W-1:0]  r_prod_g;
    logic signed [PROD_W-1:0]  r_prod_s;
    logic signed [DATA_W-1:0]  r_new_step;
    logic                      r_step_sat;
    logic                      r_out_valid;

    logic [EXT_W-1:0]             index_ext;
    logic signed [COEF_W:0]       lr_s;
    logic signed [COEF_W:0]       mom_s;
    logic signed [SUM_W-1:0]      sum_w;
    logic signed [SUM_W-RND-1:0]  step_q;
    logic                         step_fits;
    logic signed [DATA_W-1:0]     step_sel;
    logic signed [DATA_W:0]       wsum;
    logic                         w_fits;
    logic [DATA_W-1:0]            w_clip;
    logic [DATA_W-1:0]            n_weight;
    logic [DATA_W-1:0]            n_step;
    logic [DATA_W-1:0]            n_grad;
    logic                         n_sat;
    logic                         wr_all;
    logic                         wr_weight;

    assign index_ext = {{(EXT_W-INDEX_W){1'b0}}, i_entry_index};
    assign lr_s      = {1'b0, i_learning_rate};
    assign mom_s     = {1'b0, i_momentum};

    // Step: exact sum of both products, half added, floor shift by 14.
    assign sum_w     = SUM_W'(r_prod_g) + SUM_W'(r_prod_s) + SUM_W'(8192);
    assign step_q    = sum_w[SUM_W-1:RND];
    assign step_fits = (step_q[SUM_W-RND-1:DATA_W-1] == '0) ||
                       (step_q[SUM_W-RND-1:DATA_W-1] == '1);

    assign step_sel = (r_op == CMD_UPDATE) ? r_new_step : r_rd_step;
    assign wsum     = (r_op == CMD_BACK) ? ((DATA_W+1)'(r_rd_weight) - (DATA_W+1)'(step_sel))
                                         : ((DATA_W+1)'(r_rd_weight) + (DATA_W+1)'(step_sel));
    assign w_fits   = (wsum[DATA_W] == wsum[DATA_W-1]);
    assign w_clip   = w_fits ? wsum[DATA_W-1:0] : (wsum[DATA_W] ? Q_MIN : Q_MAX);

    always_comb begin
        n_weight  = '0;
        n_step    = '0;
        n_grad    = '0;
        n_sat     = 1'b0;
        wr_all    = 1'b0;
        wr_weight = 1'b0;
        if (r_in_range) begin
            case (r_op)
                CMD_LOAD: begin
                    n_weight = r_data;
                    wr_all   = 1'b1;
                end
                CMD_UPDATE: begin
                    n_weight = w_clip;
                    n_step   = r_new_step;
                    n_sat    = r_step_sat || !w_fits;
                    wr_all   = 1'b1;
                end
                CMD_BACK: begin
                    n_weight  = w_clip;
                    n_step    = r_rd_step;
                    n_grad    = r_rd_grad;
                    n_sat     = !w_fits;
                    wr_weight = 1'b1;
                end
                default: begin
                    n_weight = r_rd_weight;
                    n_step   = r_rd_step;
                end
            endcase
        end
    end

    // Item capture and arithmetic pipeline registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_op;
            r_addr     <= index_ext[IDX_W-1:0];
            r_in_range <= (index_ext < EXT_W'(ENTRIES));
            r_data     <= i_data_value;
        end
        if (i_cmd.mult) begin
            r_prod_g <= lr_s * r_data;
            r_prod_s <= mom_s * r_rd_step;
        end
        if (i_cmd.sum) begin
            r_step_sat <= !step_fits;
            r_new_step <= step_fits ? step_q[DATA_W-1:0]
                                    : (step_q[SUM_W-RND-1] ? Q_MIN : Q_MAX);
        end
    end

    // Table read and write ports. A load clears the saved gradient, an update saves it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_weight <= r_weight_mem[r_addr];
            r_rd_step   <= r_step_mem[r_addr];
            r_rd_grad   <= r_grad_mem[r_addr];
        end
        if (i_cmd.finish && (wr_all || wr_weight)) begin
            r_weight_mem[r_addr] <= n_weight;
        end
        if (i_cmd.finish && wr_all) begin
            r_step_mem[r_addr] <= n_step;
            r_grad_mem[r_addr] <= (r_op == CMD_UPDATE) ? r_data : '0;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_weight_out        <= n_weight;
            o_step_out          <= n_step;
            o_restored_gradient <= n_grad;
            o_saturated         <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("finished item did not raise the result valid");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !r_in_range) |=>
            (o_weight_out == '0) && (o_step_out == '0) && !o_saturated)
        else $error("out-of-range item returned a nonzero result");

endmodule

`default_nettype wire
